### src/atos_pkg.sv
// ----------------------------------------------------------------------------
// atos_pkg: shared widths, codes and types of the box-triangle overlap block
// Widths are derived from the coordinate width. Doubled coordinates keep the
// box centre exact, so every value below is an exact integer.
// ----------------------------------------------------------------------------
`default_nettype none

package atos_pkg;

   localparam int COORD_BITS = 24;
   // Doubled vertex relative to the doubled box centre.
   localparam int VW = COORD_BITS + 2;
   // Doubled box half-size.
   localparam int HW = COORD_BITS + 1;
   // Triangle edge.
   localparam int FW = COORD_BITS + 3;
   // Axis component (widest is the triangle normal).
   localparam int AW = 2 * FW + 1;
   // Second multiplier operand, wide enough for the magnitude of an axis component.
   localparam int BW = AW + 1;
   localparam int SPLIT_BITS = BW / 2;
   localparam int HIGH_BITS = BW - SPLIT_BITS;
   // Accumulator: a sum of three products of a vertex and an axis component.
   localparam int ACCW = VW + AW + 2;

   localparam logic [1:0] ACT_BOX_LOW = 2'd0;
   localparam logic [1:0] ACT_BOX_HIGH = 2'd1;
   localparam logic [1:0] ACT_VERTEX = 2'd2;

   localparam logic [1:0] KIND_NORM = 2'd0;
   localparam logic [1:0] KIND_DOT = 2'd1;
   localparam logic [1:0] KIND_RAD = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // Travels with each product through the multiply-accumulate pipeline.
   typedef struct packed {
      logic clear;
      logic last;
      logic lead;
      logic [1:0] kind;
   } op_tag_type;

   function automatic logic [1:0] next3(input logic [1:0] x);
      next3 = (x == 2'd2) ? 2'd0 : x + 2'd1;
   endfunction

endpackage

`default_nettype wire

### src/atos_req_if.sv
// ----------------------------------------------------------------------------
// atos_req_if: input channel of the box-triangle overlap block
// One word carries a box corner or a triangle vertex.
// ----------------------------------------------------------------------------
`default_nettype none

interface atos_req_if import atos_pkg::*; ();
   logic valid;
   logic ready;
   logic [1:0] action;
   coord_type px;
   coord_type py;
   coord_type pz;
   logic last_triangle;

   modport source (output valid, action, px, py, pz, last_triangle, input ready);
   modport sink (input valid, action, px, py, pz, last_triangle, output ready);
endinterface

`default_nettype wire

### src/atos_rsp_if.sv
// ----------------------------------------------------------------------------
// atos_rsp_if: result channel of the box-triangle overlap block
// One word per completed triangle.
// ----------------------------------------------------------------------------
`default_nettype none

interface atos_rsp_if;
   logic valid;
   logic ready;
   logic triangle_overlap;
   logic polygon_overlap;
   logic polygon_done;

   modport source (output valid, triangle_overlap, polygon_overlap, polygon_done,
                   input ready);
   modport sink (input valid, triangle_overlap, polygon_overlap, polygon_done,
                 output ready);
endinterface

`default_nettype wire

### src/atos_mac.sv
// ----------------------------------------------------------------------------
// atos_mac: shared multiply-accumulate unit
// The wide operand is split into two halves, each multiplied and registered;
// the next stage shifts, adds and accumulates.
// ----------------------------------------------------------------------------
`default_nettype none

module atos_mac import atos_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   issue_i,
   input  logic signed [FW-1:0]   a_i,
   input  logic signed [BW-1:0]   b_i,
   input  op_tag_type             tag_i,
   output logic signed [ACCW-1:0] acc_o,
   output logic                   res_valid_o,
   output op_tag_type             res_tag_o
);

   logic signed [SPLIT_BITS:0] lo_op;
   logic signed [HIGH_BITS-1:0] hi_op;
   logic signed [FW+SPLIT_BITS:0] pp_lo_ff;
   logic signed [FW+HIGH_BITS-1:0] pp_hi_ff;
   logic s1_valid_ff;
   op_tag_type s1_tag_ff;
   logic signed [ACCW-1:0] term;
   logic signed [ACCW-1:0] acc_ff;
   logic res_valid_ff;
   op_tag_type res_tag_ff;

   assign lo_op = $signed({1'b0, b_i[SPLIT_BITS-1:0]});
   assign hi_op = $signed(b_i[BW-1:SPLIT_BITS]);
   assign term = (ACCW'(pp_hi_ff) <<< SPLIT_BITS) + ACCW'(pp_lo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue_i;
         res_valid_ff <= s1_valid_ff && s1_tag_ff.last;
      end
      pp_lo_ff <= a_i * lo_op;
      pp_hi_ff <= a_i * hi_op;
      s1_tag_ff <= tag_i;
      res_tag_ff <= s1_tag_ff;
      if (s1_valid_ff) begin
         acc_ff <= s1_tag_ff.clear ? term : acc_ff + term;
      end
   end

   assign acc_o = acc_ff;
   assign res_valid_o = res_valid_ff;
   assign res_tag_o = res_tag_ff;

endmodule

`default_nettype wire

### src/atos_core.sv
// ----------------------------------------------------------------------------
// atos_core: separating-axis sequencer
// Forms the triangle normal, then walks the 13 axes: three products per
// vertex projection and three for the box radius, all on one shared unit.
// ----------------------------------------------------------------------------
`default_nettype none

module atos_core import atos_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start_i,
   input  coord_type lo_i [3],
   input  coord_type hi_i [3],
   input  coord_type p0_i [3],
   input  coord_type p1_i [3],
   input  coord_type p2_i [3],
   output logic      done_o,
   output logic      hit_o
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EDGE = 3'd1;
   localparam logic [2:0] ST_NORM = 3'd2;
   localparam logic [2:0] ST_AXIS = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;

   localparam logic [1:0] AX_BOX = 2'd0;
   localparam logic [1:0] AX_EDGE = 2'd1;
   localparam logic [1:0] AX_TRI = 2'd2;

   logic signed [VW-1:0] v_ff [3][3];
   logic signed [HW-1:0] h_ff [3];
   logic signed [FW-1:0] f_ff [3][3];
   logic signed [AW-1:0] n_ff [3];
   logic signed [ACCW-1:0] dmin_ff, dmax_ff;
   logic sep_ff;
   logic [1:0] nidx_ff;
   logic done_ff, done_in;
   logic hit_ff, hit_in;

   logic [2:0] state_ff, state_in;
   logic [1:0] axcls_ff, axcls_in;
   logic [1:0] ai_ff, ai_in;
   logic [1:0] ak_ff, ak_in;
   logic [1:0] grp_ff, grp_in;
   logic [1:0] comp_ff, comp_in;
   logic term_ff, term_in;

   logic signed [AW-1:0] ax [3];
   logic signed [AW-1:0] axk;
   logic [1:0] c1, c2;
   logic issue;
   logic signed [FW-1:0] op_a;
   logic signed [BW-1:0] op_b;
   op_tag_type tag;
   logic signed [ACCW-1:0] acc;
   logic res_valid;
   op_tag_type res_tag;
   logic sep_now;

   // Current axis: a box normal, a box normal crossed with an edge, or the normal.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         unique case (axcls_ff)
            AX_BOX:  ax[c] = (2'(c) == ai_ff) ? AW'(1) : AW'(0);
            AX_EDGE: begin
               if (2'(c) == ai_ff) begin
                  ax[c] = AW'(0);
               end else if (2'(c) == next3(ai_ff)) begin
                  ax[c] = -AW'(f_ff[ak_ff][next3(next3(ai_ff))]);
               end else begin
                  ax[c] = AW'(f_ff[ak_ff][next3(ai_ff)]);
               end
            end
            AX_TRI:  ax[c] = n_ff[c];
            default: ax[c] = AW'(0);
         endcase
      end
   end

   assign axk = ax[comp_ff];
   assign c1 = next3(comp_ff);
   assign c2 = next3(c1);
   assign issue = (state_ff == ST_NORM) || (state_ff == ST_AXIS);

   always_comb begin
      op_a = '0;
      op_b = '0;
      tag = '0;
      if (state_ff == ST_NORM) begin
         if (!term_ff) begin
            op_a = f_ff[0][c1];
            op_b = BW'(f_ff[1][c2]);
         end else begin
            op_a = f_ff[0][c2];
            op_b = -BW'(f_ff[1][c1]);
         end
         tag.clear = !term_ff;
         tag.last = term_ff;
         tag.kind = KIND_NORM;
      end else begin
         if (grp_ff != 2'd3) begin
            op_a = FW'(v_ff[grp_ff][comp_ff]);
            op_b = BW'(axk);
            tag.kind = KIND_DOT;
         end else begin
            op_a = FW'(h_ff[comp_ff]);
            op_b = axk[AW-1] ? -BW'(axk) : BW'(axk);
            tag.kind = KIND_RAD;
         end
         tag.clear = (comp_ff == 2'd0);
         tag.last = (comp_ff == 2'd2);
         tag.lead = (grp_ff == 2'd0);
      end
   end

   atos_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .issue_i     (issue),
      .a_i         (op_a),
      .b_i         (op_b),
      .tag_i       (tag),
      .acc_o       (acc),
      .res_valid_o (res_valid),
      .res_tag_o   (res_tag)
   );

   // The box radius has arrived: the projections are disjoint on this axis.
   assign sep_now = (dmax_ff < -acc) || (acc < dmin_ff);

   always_comb begin
      state_in = state_ff;
      axcls_in = axcls_ff;
      ai_in = ai_ff;
      ak_in = ak_ff;
      grp_in = grp_ff;
      comp_in = comp_ff;
      term_in = term_ff;
      done_in = 1'b0;
      hit_in = hit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_i) begin
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            state_in = ST_NORM;
            term_in = 1'b0;
            comp_in = 2'd0;
         end
         ST_NORM: begin
            term_in = !term_ff;
            if (term_ff) begin
               if (comp_ff == 2'd2) begin
                  state_in = ST_AXIS;
                  axcls_in = AX_BOX;
                  ai_in = 2'd0;
                  ak_in = 2'd0;
                  grp_in = 2'd0;
                  comp_in = 2'd0;
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end
         end
         ST_AXIS: begin
            comp_in = next3(comp_ff);
            if (comp_ff == 2'd2) begin
               grp_in = grp_ff + 2'd1;
               if (grp_ff == 2'd3) begin
                  unique case (axcls_ff)
                     AX_BOX: begin
                        ai_in = next3(ai_ff);
                        if (ai_ff == 2'd2) begin
                           axcls_in = AX_EDGE;
                        end
                     end
                     AX_EDGE: begin
                        ak_in = next3(ak_ff);
                        if (ak_ff == 2'd2) begin
                           ai_in = next3(ai_ff);
                           if (ai_ff == 2'd2) begin
                              axcls_in = AX_TRI;
                           end
                        end
                     end
                     default: begin
                        state_in = ST_DRAIN;
                     end
                  endcase
               end
            end
         end
         ST_DRAIN: begin
            if (res_valid && res_tag.kind == KIND_RAD) begin
               state_in = ST_IDLE;
               done_in = 1'b1;
               hit_in = !(sep_ff || sep_now);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      axcls_ff <= axcls_in;
      ai_ff <= ai_in;
      ak_ff <= ak_in;
      grp_ff <= grp_in;
      comp_ff <= comp_in;
      term_ff <= term_in;
      hit_ff <= hit_in;

      if (state_ff == ST_IDLE && start_i) begin
         for (int k = 0; k < 3; k++) begin
            h_ff[k] <= HW'(hi_i[k]) - HW'(lo_i[k]);
            v_ff[0][k] <= (VW'(p0_i[k]) <<< 1) - (VW'(lo_i[k]) + VW'(hi_i[k]));
            v_ff[1][k] <= (VW'(p1_i[k]) <<< 1) - (VW'(lo_i[k]) + VW'(hi_i[k]));
            v_ff[2][k] <= (VW'(p2_i[k]) <<< 1) - (VW'(lo_i[k]) + VW'(hi_i[k]));
         end
         sep_ff <= 1'b0;
         nidx_ff <= 2'd0;
      end else if (res_valid) begin
         unique case (res_tag.kind)
            KIND_NORM: begin
               n_ff[nidx_ff] <= AW'(acc);
               nidx_ff <= next3(nidx_ff);
            end
            KIND_DOT: begin
               if (res_tag.lead) begin
                  dmin_ff <= acc;
                  dmax_ff <= acc;
               end else begin
                  if (acc < dmin_ff) begin
                     dmin_ff <= acc;
                  end
                  if (dmax_ff < acc) begin
                     dmax_ff <= acc;
                  end
               end
            end
            KIND_RAD: begin
               sep_ff <= sep_ff || sep_now;
            end
            default: begin
            end
         endcase
      end

      if (state_ff == ST_EDGE) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               f_ff[i][k] <= FW'(v_ff[(i + 1) % 3][k]) - FW'(v_ff[i][k]);
            end
         end
      end
   end

   assign done_o = done_ff;
   assign hit_o = hit_ff;

endmodule

`default_nettype wire

### src/aabb_triangle_overlap_sat.sv
// ----------------------------------------------------------------------------
// aabb_triangle_overlap_sat: box against triangle overlap, separating axes
//
//   channel   direction  word
//   req_ch    in         action, px, py, pz, last_triangle
//   rsp_ch    out        triangle_overlap, polygon_overlap, polygon_done
//
// Box corners and the first two vertices of a triangle are stored on acceptance.
// The third vertex keeps the block busy while 162 products run one per
// cycle through the single multiply-accumulate unit.
// A result waits in the output register while new words are taken.
// Reset is synchronous; the box resets to zero and the running flag clears.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_triangle_overlap_sat import atos_pkg::*; (
   input logic        clock,
   input logic        reset,
   atos_req_if.sink   req_ch,
   atos_rsp_if.source rsp_ch
);

   coord_type box_lo_ff [3];
   coord_type box_hi_ff [3];
   coord_type vtx0_ff [3];
   coord_type vtx1_ff [3];
   coord_type pt [3];
   logic [1:0] vcount_ff;
   logic any_hit_ff;
   logic busy_ff;
   logic wait_ff;
   logic last_ff;
   logic rsp_valid_ff;
   logic rsp_tri_ff, rsp_poly_ff, rsp_done_ff;
   logic accept;
   logic start;
   logic core_done;
   logic core_hit;
   logic move;

   assign pt[0] = req_ch.px;
   assign pt[1] = req_ch.py;
   assign pt[2] = req_ch.pz;
   assign req_ch.ready = !busy_ff;
   assign accept = req_ch.valid && !busy_ff;
   assign start = accept && req_ch.action == ACT_VERTEX && vcount_ff == 2'd2;
   assign move = wait_ff && (!rsp_valid_ff || rsp_ch.ready);

   atos_core u_core (
      .clock   (clock),
      .reset   (reset),
      .start_i (start),
      .lo_i    (box_lo_ff),
      .hi_i    (box_hi_ff),
      .p0_i    (vtx0_ff),
      .p1_i    (vtx1_ff),
      .p2_i    (pt),
      .done_o  (core_done),
      .hit_o   (core_hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            box_lo_ff[k] <= '0;
            box_hi_ff[k] <= '0;
         end
         vcount_ff <= 2'd0;
         any_hit_ff <= 1'b0;
         busy_ff <= 1'b0;
         wait_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            unique case (req_ch.action)
               ACT_BOX_LOW: begin
                  box_lo_ff <= pt;
                  any_hit_ff <= 1'b0;
                  vcount_ff <= 2'd0;
               end
               ACT_BOX_HIGH: begin
                  box_hi_ff <= pt;
                  any_hit_ff <= 1'b0;
                  vcount_ff <= 2'd0;
               end
               ACT_VERTEX: begin
                  unique case (vcount_ff)
                     2'd0: begin
                        vtx0_ff <= pt;
                        vcount_ff <= 2'd1;
                     end
                     2'd1: begin
                        vtx1_ff <= pt;
                        vcount_ff <= 2'd2;
                     end
                     default: begin
                        vcount_ff <= 2'd0;
                        busy_ff <= 1'b1;
                        last_ff <= req_ch.last_triangle;
                     end
                  endcase
               end
               default: begin
               end
            endcase
         end
         if (core_done) begin
            wait_ff <= 1'b1;
         end
         if (move) begin
            wait_ff <= 1'b0;
            busy_ff <= 1'b0;
            any_hit_ff <= any_hit_ff || core_hit;
            rsp_valid_ff <= 1'b1;
            rsp_tri_ff <= core_hit;
            rsp_poly_ff <= any_hit_ff || core_hit;
            rsp_done_ff <= last_ff;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.triangle_overlap = rsp_tri_ff;
   assign rsp_ch.polygon_overlap = rsp_poly_ff;
   assign rsp_ch.polygon_done = rsp_done_ff;

endmodule

`default_nettype wire
